FILE: sv/mdc_pkg.sv
// Shared constants, types and permutation tables for the cofactor determinant block.
package mdc_pkg;

   localparam int MAX_DIM         = 4;
   localparam int MAX_PERMS       = 24;
   localparam int DIM_DEF         = 3;
   localparam int ELEM_BITS_DEF   = 16;
   localparam int IN_BITS         = 16;
   localparam int DET_BITS        = 64;
   localparam int STORE_ADDR_BITS = 4;
   // widest exact partial product that enters the multiplier: (MAX_DIM-1) entries
   localparam int MULT_A_BITS     = (MAX_DIM - 1) * IN_BITS;

   typedef logic [MAX_PERMS-1:0][MAX_DIM-1:0][1:0] perm_tab_type;
   typedef logic [MAX_PERMS-1:0]                   perm_sign_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_ACC  = 3'b100
   } state_type;

   typedef struct packed {
      logic                       en;
      logic [STORE_ADDR_BITS-1:0] addr;
      logic [IN_BITS-1:0]         data;
   } store_wr_type;

   function automatic int num_perms(input int dim);
      int n;
      n = 1;
      for (int i = 2; i <= dim; i++) n = n * i;
      return n;
   endfunction

   // true when the base-4 digits of t form a permutation of 0..dim-1
   function automatic logic is_perm(input logic [7:0] t, input int dim);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < MAX_DIM; i++) begin
         if (i < dim) begin
            if (int'(t[2*i +: 2]) >= dim) ok = 1'b0;
         end else if (t[2*i +: 2] != 2'd0) begin
            ok = 1'b0;
         end
      end
      for (int i = 0; i < MAX_DIM; i++)
         for (int j = i + 1; j < MAX_DIM; j++)
            if (j < dim && t[2*i +: 2] == t[2*j +: 2]) ok = 1'b0;
      return ok;
   endfunction

   // odd inversion count means a negative term
   function automatic logic perm_parity(input logic [7:0] t, input int dim);
      logic odd;
      odd = 1'b0;
      for (int i = 0; i < MAX_DIM; i++)
         for (int j = i + 1; j < MAX_DIM; j++)
            if (j < dim && t[2*i +: 2] > t[2*j +: 2]) odd = ~odd;
      return odd;
   endfunction

   function automatic perm_tab_type perm_tab(input int dim);
      perm_tab_type tab;
      int           n;
      logic [7:0]   t;
      tab = '0;
      n   = 0;
      for (int v = 0; v < 256; v++) begin
         t = v[7:0];
         if (is_perm(t, dim) && n < MAX_PERMS) begin
            for (int i = 0; i < MAX_DIM; i++) tab[n][i] = t[2*i +: 2];
            n++;
         end
      end
      return tab;
   endfunction

   function automatic perm_sign_type perm_signs(input int dim);
      perm_sign_type sg;
      int            n;
      logic [7:0]    t;
      sg = '0;
      n  = 0;
      for (int v = 0; v < 256; v++) begin
         t = v[7:0];
         if (is_perm(t, dim) && n < MAX_PERMS) begin
            sg[n] = perm_parity(t, dim);
            n++;
         end
      end
      return sg;
   endfunction

endpackage

FILE: sv/mdc_store.sv
// Entry store: one write port from the input side, one read port for the sequencer.
module mdc_store
   import mdc_pkg::*;
#(
   parameter int CELLS     = DIM_DEF * DIM_DEF,
   parameter int ELEM_BITS = ELEM_BITS_DEF,
   parameter int IDX_W     = (CELLS > 1) ? $clog2(CELLS) : 1
) (
   input  logic                        clock,
   input  store_wr_type                wr,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic signed [ELEM_BITS-1:0] rd_data
);

   logic [ELEM_BITS-1:0] mem_ff [CELLS];
   logic [ELEM_BITS-1:0] rd_data_ff;

   // keep only the low entry bits; a read of the cell being written returns the new entry
   always_ff @(posedge clock) begin
      if (wr.en) mem_ff[wr.addr[IDX_W-1:0]] <= wr.data[ELEM_BITS-1:0];
      if (wr.en && wr.addr[IDX_W-1:0] == rd_addr) begin
         rd_data_ff <= wr.data[ELEM_BITS-1:0];
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = $signed(rd_data_ff);

endmodule

FILE: sv/mdc_mult.sv
// Shared signed multiplier: partial product times one matrix entry.
module mdc_mult
   import mdc_pkg::*;
#(
   parameter int ELEM_BITS = ELEM_BITS_DEF
) (
   input  logic signed [MULT_A_BITS-1:0] a,
   input  logic signed [ELEM_BITS-1:0]   b,
   output logic signed [DET_BITS-1:0]    p
);

   logic signed [MULT_A_BITS+ELEM_BITS-1:0] full;

   assign full = a * b;
   // sign-extend narrow products up to the result width
   assign p    = DET_BITS'(full);

endmodule

FILE: sv/matrix_determinant_cofactor.sv
// Top level: entry loading, permutation sequencer and determinant accumulation.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   request  | start / busy         | req_element (16 b, signed)
//   response | rsp_valid (strobe)   | rsp_determinant (64 b, signed)
//
// Each item that does not complete a matrix is taken without raising busy.
// The item that completes a matrix raises busy for the whole term sweep:
// the single multiplier builds one product factor per cycle for each signed
// permutation term, and then an accumulate step adds the term into the sum.
// The result strobes for one cycle, in the same cycle that busy drops; the
// receiver cannot stall it. Reset clears the entry count and the sequencer;
// store contents are left as they are.
module matrix_determinant_cofactor
   import mdc_pkg::*;
#(
   parameter int DIM       = DIM_DEF,
   parameter int ELEM_BITS = ELEM_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [IN_BITS-1:0]  req_element,
   output logic                       rsp_valid,
   output logic signed [DET_BITS-1:0] rsp_determinant
);

   localparam int            CELLS  = DIM * DIM;
   localparam int            IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int            COL_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int            NPERMS = num_perms(DIM);
   localparam int            PERM_W = (NPERMS > 1) ? $clog2(NPERMS) : 1;
   localparam perm_tab_type  PERMS  = perm_tab(DIM);
   localparam perm_sign_type SIGNS  = perm_signs(DIM);

   localparam logic [IDX_W-1:0]  LAST_CELL = IDX_W'(CELLS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(DIM - 1);
   localparam logic [PERM_W-1:0] LAST_PERM = PERM_W'(NPERMS - 1);

   state_type                   state_ff, state_in;
   logic [IDX_W-1:0]            count_ff, count_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [PERM_W-1:0]           perm_ff, perm_in;
   logic signed [DET_BITS-1:0]  prod_ff, prod_in;
   logic signed [DET_BITS-1:0]  acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [DET_BITS-1:0]  rsp_det_ff, rsp_det_in;

   store_wr_type                wr;
   logic [IDX_W-1:0]            rd_addr;
   logic [COL_W-1:0]            rd_col;
   logic signed [ELEM_BITS-1:0] rd_data;
   logic signed [MULT_A_BITS-1:0] mult_a;
   logic signed [DET_BITS-1:0]  mult_p;
   logic signed [DET_BITS-1:0]  acc_sum;

   // the store read is registered: address the entry for the next step, so it
   // lands as row col_ff, column from the current permutation
   assign rd_col  = COL_W'(PERMS[perm_in][col_in]);
   assign rd_addr = IDX_W'(col_in) * IDX_W'(DIM) + IDX_W'(rd_col);

   mdc_store #(
      .CELLS     (CELLS),
      .ELEM_BITS (ELEM_BITS),
      .IDX_W     (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // first factor of a term multiplies by one, later ones by the partial product
   assign mult_a = (col_ff == '0) ? MULT_A_BITS'(1) : prod_ff[MULT_A_BITS-1:0];

   mdc_mult #(
      .ELEM_BITS (ELEM_BITS)
   ) u_mult (
      .a (mult_a),
      .b (rd_data),
      .p (mult_p)
   );

   assign acc_sum = SIGNS[perm_ff] ? (acc_ff - prod_ff) : (acc_ff + prod_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      col_in       = col_ff;
      perm_in      = perm_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_det_in   = rsp_det_ff;
      wr.en        = 1'b0;
      wr.addr      = STORE_ADDR_BITS'(count_ff);
      wr.data      = req_element;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               wr.en = 1'b1;
               if (count_ff == LAST_CELL) begin
                  // matrix complete: start the term sweep
                  count_in = '0;
                  col_in   = '0;
                  perm_in  = '0;
                  acc_in   = '0;
                  state_in = S_CALC;
               end else begin
                  count_in = count_ff + IDX_W'(1);
               end
            end
         end
         S_CALC: begin
            prod_in = mult_p;
            if (col_ff == LAST_COL) begin
               state_in = S_ACC;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         S_ACC: begin
            acc_in = acc_sum;
            col_in = '0;
            if (perm_ff == LAST_PERM) begin
               rsp_valid_in = 1'b1;
               rsp_det_in   = acc_sum;
               state_in     = S_IDLE;
            end else begin
               perm_in  = perm_ff + PERM_W'(1);
               state_in = S_CALC;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         col_ff       <= '0;
         perm_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         col_ff       <= col_in;
         perm_ff      <= perm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rsp_det_ff <= rsp_det_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_determinant = rsp_det_ff;

`ifndef SYNTHESIS
   a_rsp_after_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_ACC))
      else $error("result strobe without a final accumulate");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_last_entry_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && count_ff == LAST_CELL) |=> (state_ff == S_CALC && col_ff == '0))
      else $error("completed matrix did not start the term sweep");

   a_count_idle_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff == '0 && !rsp_valid))
      else $error("entry count or result active during the sweep");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the cofactor determinant block, driven item by item.
module testbench;
   import mdc_pkg::*;

   localparam int DIM         = DIM_DEF;
   localparam int ELEM_BITS   = ELEM_BITS_DEF;
   localparam int CELLS       = DIM * DIM;
   // the completing item keeps the block busy while it sweeps the permutation terms
   localparam int SETTLE      = 40;
   localparam int CYCLE_LIMIT = 250000;
   localparam int MAX_REPORTS = 10;

   // value styles for the random matrices
   localparam int STYLE_FULL     = 0;
   localparam int STYLE_SMALL    = 1;
   localparam int STYLE_EXTREME  = 2;
   localparam int STYLE_SINGULAR = 3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic signed [IN_BITS-1:0]  req_element = '0;
   logic                       rsp_valid;
   logic signed [DET_BITS-1:0] rsp_determinant;

   // local copy of the matrix being loaded and the count of its entries
   logic [IN_BITS-1:0]         entries [CELLS];
   int unsigned                loaded = 0;
   // determinants owed by the block, oldest first
   logic signed [DET_BITS-1:0] pending_dets [$];
   logic signed [DET_BITS-1:0] owed_det;
   int                         mismatch_count = 0;
   int                         cycle_count = 0;

   matrix_determinant_cofactor #(
      .DIM       (DIM),
      .ELEM_BITS (ELEM_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_determinant (rsp_determinant)
   );

   always #5 clock = ~clock;

   // Bound the run: a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Count every failure; print only the first few in full.
   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0d] FAIL: %s", cycle_count, msg);
   endtask

   // Sign-extend the low ELEM_BITS bits of one stored entry to the result width.
   function automatic logic signed [DET_BITS-1:0] entry_value(input int row, input int col);
      logic [DET_BITS-1:0] v;
      v = '0;
      v[ELEM_BITS-1:0] = entries[row * DIM + col][ELEM_BITS-1:0];
      if (v[ELEM_BITS-1])
         v[DET_BITS-1:ELEM_BITS] = '1;
      return v;
   endfunction

   // Determinant as the signed sum over all column permutations. This equals the
   // row-0 cofactor expansion exactly, since both are ring identities mod 2^64.
   function automatic logic signed [DET_BITS-1:0] cofactor_det();
      logic signed [DET_BITS-1:0] sum;
      logic signed [DET_BITS-1:0] term;
      int                         col_of [DIM];
      int                         rest;
      bit                         distinct;
      bit                         odd;
      sum = '0;
      for (int code = 0; code < DIM ** DIM; code++) begin
         rest = code;
         for (int r = 0; r < DIM; r++) begin
            col_of[r] = rest % DIM;
            rest      = rest / DIM;
         end
         distinct = 1'b1;
         odd      = 1'b0;
         for (int i = 0; i < DIM; i++)
            for (int j = i + 1; j < DIM; j++) begin
               if (col_of[i] == col_of[j]) distinct = 1'b0;
               if (col_of[i] > col_of[j]) odd = ~odd;
            end
         if (distinct) begin
            term = 1;
            for (int r = 0; r < DIM; r++)
               term = term * entry_value(r, col_of[r]);
            sum = odd ? sum - term : sum + term;
         end
      end
      return sum;
   endfunction

   // Send one item. Idle the request side first for a random gap, then hold
   // start until an edge sees busy low. Start is left high on return so that a
   // back-to-back item does not drop it for a cycle.
   task automatic load_element(input logic [IN_BITS-1:0] value, input int gap_pct);
      int gap;
      gap = 0;
      if (int'($urandom_range(0, 99)) < gap_pct)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_element <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted: advance the local copy, and owe a determinant on the last entry
      if (loaded >= CELLS) loaded = 0;
      entries[loaded] = value;
      loaded++;
      if (loaded == CELLS) begin
         loaded = 0;
         pending_dets.push_back(cofactor_det());
      end
   endtask

   task automatic load_row(input logic [IN_BITS-1:0] a, b, c, input int gap_pct);
      load_element(a, gap_pct);
      load_element(b, gap_pct);
      load_element(c, gap_pct);
   endtask

   // One random matrix in one of several value styles.
   task automatic load_random_matrix(input int gap_pct);
      logic [IN_BITS-1:0] row0 [DIM];
      logic [IN_BITS-1:0] value;
      int                 style;
      int                 small_val;
      style = $urandom_range(STYLE_FULL, STYLE_SINGULAR);
      for (int idx = 0; idx < CELLS; idx++) begin
         case (style)
            STYLE_SMALL: begin
               small_val = int'($urandom_range(0, 8)) - 4;
               value     = small_val[IN_BITS-1:0];
            end
            STYLE_EXTREME: begin
               case ($urandom_range(0, 4))
                  0:       value = 16'h8000;
                  1:       value = 16'h7fff;
                  2:       value = 16'hffff;
                  3:       value = 16'h0001;
                  default: value = 16'h0000;
               endcase
            end
            STYLE_SINGULAR: begin
               // repeat row 0 as the last row, so the determinant is zero
               if (idx >= CELLS - DIM) value = row0[idx - (CELLS - DIM)];
               else value = IN_BITS'($urandom_range(0, 65535));
            end
            default: value = IN_BITS'($urandom_range(0, 65535));
         endcase
         if (idx < DIM) row0[idx] = value;
         load_element(value, gap_pct);
      end
   endtask

   // Extremes of the entry range, the unit constants and a degenerate matrix.
   task automatic test_extreme_matrices();
      // largest magnitudes of both signs, mixed so the determinant is large
      load_row(16'h8000, 16'h7fff, 16'h7fff, 0);
      load_row(16'h7fff, 16'h8000, 16'h7fff, 0);
      load_row(16'h7fff, 16'h7fff, 16'h8000, 0);
      // diagonal of one and minus one
      load_row(16'h0001, 16'h0000, 16'h0000, 50);
      load_row(16'h0000, 16'hffff, 16'h0000, 50);
      load_row(16'h0000, 16'h0000, 16'h0001, 50);
      // every entry the most negative value: singular
      load_row(16'h8000, 16'h8000, 16'h8000, 0);
      load_row(16'h8000, 16'h8000, 16'h8000, 0);
      load_row(16'h8000, 16'h8000, 16'h8000, 0);
   endtask

   // Items offered back to back, so start is high while the block is busy.
   task automatic test_back_to_back(input int matrices);
      repeat (matrices) load_random_matrix(0);
   endtask

   // Sparse requests: a random gap before most items, so starts fall at varied points of the busy window.
   task automatic test_sparse_requests(input int matrices);
      repeat (matrices) load_random_matrix(67);
   endtask

   // Mixed gaps, with an occasional burst of back-to-back matrices.
   task automatic test_mixed_gaps(input int matrices);
      repeat (matrices) load_random_matrix(($urandom_range(0, 3) == 0) ? 0 : 38);
   endtask

   // Compare each strobed determinant with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_dets.size() == 0) begin
            note_failure($sformatf("determinant %0d with none owed", rsp_determinant));
         end else begin
            owed_det = pending_dets.pop_front();
            if (rsp_determinant !== owed_det)
               note_failure($sformatf("determinant: expected %0d, got %0d",
                                      owed_det, rsp_determinant));
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_matrices();
      test_back_to_back(42);
      test_sparse_requests(42);
      test_mixed_gaps(42);

      // drop the request side, drain what is owed, then let the block settle
      start <= 1'b0;
      while (pending_dets.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (pending_dets.size() != 0)
         note_failure($sformatf("%0d determinants never arrived", pending_dets.size()));

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
